### design/chacha20_block_function_macros.svh
// assertion macros shared by the chacha20 block function modules
`ifndef CHACHA20_BLOCK_FUNCTION_MACROS_SVH
`define CHACHA20_BLOCK_FUNCTION_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define CCB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define CCB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/ccb_pkg.sv
// types, constants and round functions of the chacha20 block function
package ccb_pkg;

  localparam int WORD_W                = 32;
  localparam int BLOCK_WORDS           = 16;
  localparam int IDX_W                 = 4;
  localparam int KEY_WORDS             = 8;
  localparam int NONCE_WORDS           = 3;
  localparam int STEPS_PER_DR          = 8;
  localparam int STEP_W                = 3;
  localparam int DOUBLE_ROUNDS_DEFAULT = 10;

  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(BLOCK_WORDS - 1);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS_PER_DR - 1);

  // configuration port
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_ADDR_W  = 6;
  localparam int CFG_SEL_LSB = 3;
  localparam int CFG_SEL_W   = 3;

  // fixed words "expand 32-byte k", word 0 lowest
  localparam logic [3:0][WORD_W-1:0] SIGMA = {
    32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865
  };

  localparam int unsigned ROT_A = 16;
  localparam int unsigned ROT_B = 12;
  localparam int unsigned ROT_C = 8;
  localparam int unsigned ROT_D = 7;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [BLOCK_WORDS-1:0][WORD_W-1:0] words_t;

  typedef struct packed {
    logic [KEY_WORDS-1:0][WORD_W-1:0]   key;
    logic [NONCE_WORDS-1:0][WORD_W-1:0] nonce;
  } cfg_t;

  // what one cell hands to the next
  typedef struct packed {
    words_t words;
    word_t  ctr;
  } cell_bus_t;

  typedef enum logic [CFG_SEL_W-1:0] {
    REG_KEY_01,
    REG_KEY_23,
    REG_KEY_45,
    REG_KEY_67,
    REG_NONCE_01,
    REG_NONCE_2
  } reg_idx_e;

  // the four add-xor-rotate steps of a quarter round
  typedef enum logic [1:0] {
    SUB_AB_16,
    SUB_CD_12,
    SUB_AB_8,
    SUB_CD_7
  } sub_e;

  function automatic word_t rotl(word_t v, int unsigned n);
    return (v << n) | (v >> (WORD_W - n));
  endfunction

  // initial state from constants, key, counter and nonce
  function automatic words_t build_init(cfg_t cfg, word_t ctr);
    words_t w;
    w        = '0;
    w[3:0]   = SIGMA;
    w[11:4]  = cfg.key;
    w[12]    = ctr;
    w[15:13] = cfg.nonce;
    return w;
  endfunction

  // one step of all four quarter rounds; step[2] picks the diagonal round
  function automatic words_t qr_step(words_t s, logic [STEP_W-1:0] step);
    words_t     r;
    logic [1:0] lb, lc, ld, lj;
    logic [3:0] ia, ib, ic, id;
    word_t      sum;
    r = s;
    for (int j = 0; j < 4; j++) begin
      lj = 2'(j);
      lb = lj + (step[2] ? 2'd1 : 2'd0);
      lc = lj + (step[2] ? 2'd2 : 2'd0);
      ld = lj + (step[2] ? 2'd3 : 2'd0);
      ia = {2'b00, lj};
      ib = {2'b01, lb};
      ic = {2'b10, lc};
      id = {2'b11, ld};
      case (sub_e'(step[1:0]))
        SUB_AB_16: begin
          sum   = s[ia] + s[ib];
          r[ia] = sum;
          r[id] = rotl(s[id] ^ sum, ROT_A);
        end
        SUB_CD_12: begin
          sum   = s[ic] + s[id];
          r[ic] = sum;
          r[ib] = rotl(s[ib] ^ sum, ROT_B);
        end
        SUB_AB_8: begin
          sum   = s[ia] + s[ib];
          r[ia] = sum;
          r[id] = rotl(s[id] ^ sum, ROT_C);
        end
        SUB_CD_7: begin
          sum   = s[ic] + s[id];
          r[ic] = sum;
          r[ib] = rotl(s[ib] ^ sum, ROT_D);
        end
        default: begin
          r = s;
        end
      endcase
    end
    return r;
  endfunction

endpackage

### design/ccb_cfg.sv
// key and nonce registers behind the apb-style configuration port
module ccb_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ccb_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [ccb_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [ccb_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready,
  output ccb_pkg::cfg_t                   cfg_o
);

  ccb_pkg::cfg_t     cfg_q;
  logic              wr_en;
  ccb_pkg::reg_idx_e sel;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign sel    = ccb_pkg::reg_idx_e'(
                    paddr[ccb_pkg::CFG_ADDR_W-1:ccb_pkg::CFG_SEL_LSB]);
  assign cfg_o  = cfg_q;

  // register writes, unknown addresses dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      case (sel)
        ccb_pkg::REG_KEY_01:   cfg_q.key[1:0]   <= pwdata;
        ccb_pkg::REG_KEY_23:   cfg_q.key[3:2]   <= pwdata;
        ccb_pkg::REG_KEY_45:   cfg_q.key[5:4]   <= pwdata;
        ccb_pkg::REG_KEY_67:   cfg_q.key[7:6]   <= pwdata;
        ccb_pkg::REG_NONCE_01: cfg_q.nonce[1:0] <= pwdata;
        ccb_pkg::REG_NONCE_2:  cfg_q.nonce[2]   <= pwdata[ccb_pkg::WORD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // read back
  always_comb begin
    case (sel)
      ccb_pkg::REG_KEY_01:   prdata = cfg_q.key[1:0];
      ccb_pkg::REG_KEY_23:   prdata = cfg_q.key[3:2];
      ccb_pkg::REG_KEY_45:   prdata = cfg_q.key[5:4];
      ccb_pkg::REG_KEY_67:   prdata = cfg_q.key[7:6];
      ccb_pkg::REG_NONCE_01: prdata = cfg_q.nonce[1:0];
      ccb_pkg::REG_NONCE_2:  prdata = {{ccb_pkg::WORD_W{1'b0}}, cfg_q.nonce[2]};
      default:               prdata = '0;
    endcase
  end

endmodule

### design/ccb_cell.sv
// one double-round cell: holds a block state and runs eight quarter-round steps
`include "chacha20_block_function_macros.svh"

module ccb_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  ccb_pkg::cell_bus_t  in_bus_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  output ccb_pkg::cell_bus_t  out_bus_o,
  input  logic                out_ready_i
);

  logic                        valid_q;
  logic                        done_q;
  logic [ccb_pkg::STEP_W-1:0]  step_q;
  ccb_pkg::cell_bus_t          bus_q;
  logic                        take;

  assign in_ready_o  = !valid_q;
  assign take        = in_valid_i && !valid_q;
  assign out_valid_o = valid_q && done_q;
  assign out_bus_o   = bus_q;

  // control: load, step through the double round, hand on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      done_q  <= 1'b0;
      step_q  <= '0;
    end else if (take) begin
      valid_q <= 1'b1;
      done_q  <= 1'b0;
      step_q  <= '0;
    end else if (valid_q && !done_q) begin
      step_q <= step_q + 1'b1;
      if (step_q == ccb_pkg::LAST_STEP) begin
        done_q <= 1'b1;
      end
    end else if (out_valid_o && out_ready_i) begin
      valid_q <= 1'b0;
      done_q  <= 1'b0;
    end
  end

  // state words
  always_ff @(posedge clk_i) begin
    if (take) begin
      bus_q <= in_bus_i;
    end else if (valid_q && !done_q) begin
      bus_q.words <= ccb_pkg::qr_step(bus_q.words, step_q);
    end
  end

  `CCB_ASSERT_IMP(a_cell_done_holds, done_q, valid_q, "cell finished with no item held")
  `CCB_ASSERT_NXT(a_cell_load, take, valid_q && !done_q && step_q == '0, "cell load did not restart steps")

endmodule

### design/ccb_out.sv
// output serializer: adds the initial state and sends one keystream word a cycle while the output is not stalled
`include "chacha20_block_function_macros.svh"

module ccb_out (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ccb_pkg::cfg_t                   cfg_i,
  input  logic                            in_valid_i,
  input  ccb_pkg::cell_bus_t              in_bus_i,
  output logic                            in_ready_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [ccb_pkg::IDX_W-1:0]       word_index_o,
  output logic [ccb_pkg::WORD_W-1:0]      keystream_word_o,
  output logic                            last_word_o
);

  logic                         blk_valid_q;
  logic [ccb_pkg::IDX_W-1:0]    idx_q;
  ccb_pkg::words_t              words_q;
  ccb_pkg::word_t               ctr_q;
  logic                         out_valid_q;
  logic [ccb_pkg::IDX_W-1:0]    out_idx_q;
  ccb_pkg::word_t               out_word_q;
  logic                         out_last_q;
  logic                         out_load;
  logic                         emit;
  logic                         take;
  ccb_pkg::words_t              init_words;

  assign out_load   = !out_valid_q || !out_stall_i;
  assign emit       = blk_valid_q && out_load;
  assign in_ready_o = !blk_valid_q || (emit && idx_q == ccb_pkg::LAST_IDX);
  assign take       = in_valid_i && in_ready_o;
  assign init_words = ccb_pkg::build_init(cfg_i, ctr_q);

  assign out_valid_o      = out_valid_q;
  assign word_index_o     = out_idx_q;
  assign keystream_word_o = out_word_q;
  assign last_word_o      = out_last_q;

  // block control and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_valid_q <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        blk_valid_q <= 1'b1;
        idx_q       <= '0;
      end else if (emit) begin
        idx_q <= idx_q + 1'b1;
        if (idx_q == ccb_pkg::LAST_IDX) begin
          blk_valid_q <= 1'b0;
        end
      end
      if (out_load) begin
        out_valid_q <= emit;
      end
    end
  end

  // block words shift down as they are sent
  always_ff @(posedge clk_i) begin
    if (take) begin
      words_q <= in_bus_i.words;
      ctr_q   <= in_bus_i.ctr;
    end else if (emit) begin
      words_q <= {{ccb_pkg::WORD_W{1'b0}}, words_q[ccb_pkg::BLOCK_WORDS-1:1]};
    end
  end

  // output register: final add with the initial word
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_word_q <= words_q[0] + init_words[idx_q];
      out_idx_q  <= idx_q;
      out_last_q <= (idx_q == ccb_pkg::LAST_IDX);
    end
  end

  `CCB_ASSERT_NXT(a_out_load, take, blk_valid_q && idx_q == '0, "serializer load did not restart index")
  `CCB_ASSERT_IMP(a_out_last, out_valid_q && out_last_q, out_idx_q == ccb_pkg::LAST_IDX, "last flag off the final word")

endmodule

### design/chacha20_block_function.sv
// chacha20 block function top level: config registers, double-round cell chain, serializer
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+---------------------------------------
//  in       | in        | in_valid_i / in_stall_o   | block_counter_i
//  out      | out       | out_valid_o / out_stall_i | word_index_o, keystream_word_o,
//           |           |                           | last_word_o
//  cfg      | in        | psel/penable/pwrite/pready| paddr (reg i at 8*i), pwdata, prdata
//
// each item gives 16 words; the serializer sends one word a cycle while the output is
// not stalled, and sets the sustained rate. each double-round cell runs 8 steps between
// load and hand-on and takes no new item before it has handed on the last; the chain
// keeps up. reset clears the config registers to zero and empties the chain; a stalled
// output holds the chain back cell by cell.
module chacha20_block_function #(
  parameter int DOUBLE_ROUNDS = ccb_pkg::DOUBLE_ROUNDS_DEFAULT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [ccb_pkg::WORD_W-1:0]      block_counter_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [ccb_pkg::IDX_W-1:0]       word_index_o,
  output logic [ccb_pkg::WORD_W-1:0]      keystream_word_o,
  output logic                            last_word_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ccb_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [ccb_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [ccb_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);

  ccb_pkg::cfg_t      cfg;
  ccb_pkg::cell_bus_t bus   [DOUBLE_ROUNDS+1];
  logic               vld   [DOUBLE_ROUNDS+1];
  logic               rdy   [DOUBLE_ROUNDS+1];

  // configuration registers
  ccb_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // initial state enters the first cell
  assign vld[0]       = in_valid_i;
  assign bus[0].words = ccb_pkg::build_init(cfg, block_counter_i);
  assign bus[0].ctr   = block_counter_i;
  assign in_stall_o   = !rdy[0];

  // chain of double-round cells
  for (genvar k = 0; k < DOUBLE_ROUNDS; k++) begin : g_cell
    ccb_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (vld[k]),
      .in_bus_i    (bus[k]),
      .in_ready_o  (rdy[k]),
      .out_valid_o (vld[k+1]),
      .out_bus_o   (bus[k+1]),
      .out_ready_i (rdy[k+1])
    );
  end

  // final add and word serializer
  ccb_out u_out (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .in_valid_i       (vld[DOUBLE_ROUNDS]),
    .in_bus_i         (bus[DOUBLE_ROUNDS]),
    .in_ready_o       (rdy[DOUBLE_ROUNDS]),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .word_index_o     (word_index_o),
    .keystream_word_o (keystream_word_o),
    .last_word_o      (last_word_o)
  );

endmodule

### tb/tb_chacha20_block_function.sv
// self-checking testbench for the chacha20 block function, driven through the counter channel and the config port
`timescale 1ns / 100ps

module tb_chacha20_block_function;

  // widths and sizes taken from the package
  localparam int WORD_W        = ccb_pkg::WORD_W;
  localparam int IDX_W         = ccb_pkg::IDX_W;
  localparam int BLOCK_WORDS   = ccb_pkg::BLOCK_WORDS;
  localparam int CFG_ADDR_W    = ccb_pkg::CFG_ADDR_W;
  localparam int CFG_DATA_W    = ccb_pkg::CFG_DATA_W;
  localparam int DOUBLE_ROUNDS = ccb_pkg::DOUBLE_ROUNDS_DEFAULT;

  // register slots beyond the last one, writes there must be ignored
  localparam int SPARE_IDX_LO = 6;
  localparam int SPARE_IDX_HI = 7;
  localparam int NUM_CFG_REGS = 6;
  localparam int DRAIN_CYCLES = 2 * (9 * DOUBLE_ROUNDS + 2) + 20;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [WORD_W-1:0] word;
    logic              last;
  } ks_word_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [WORD_W-1:0]     block_counter_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [IDX_W-1:0]      word_index_o;
  logic [WORD_W-1:0]     keystream_word_o;
  logic                  last_word_o;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // shadow copy of the key and nonce registers
  logic [CFG_DATA_W-1:0] cfg_shadow [NUM_CFG_REGS];

  logic [WORD_W-1:0] ctr_queue [$];
  ks_word_t          ks_pending [$];

  bit idle_on = 1'b1;
  int in_gap = 0;
  int out_hold = 0;
  int err_count = 0;
  int items_taken = 0;
  int words_seen = 0;
  int cfg_writes = 0;

  chacha20_block_function u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .block_counter_i  (block_counter_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .word_index_o     (word_index_o),
    .keystream_word_o (keystream_word_o),
    .last_word_o      (last_word_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [WORD_W-1:0] rol32(logic [WORD_W-1:0] v, int n);
    return (v << n) | (v >> (WORD_W - n));
  endfunction

  // append one counter item to the pending queue
  function automatic void add_ctr(logic [WORD_W-1:0] c);
    ctr_queue = {ctr_queue, c};
  endfunction

  // keystream of one block for the current key and nonce, queued word by word
  function automatic void push_keystream(logic [WORD_W-1:0] ctr);
    logic [WORD_W-1:0] seed [BLOCK_WORDS];
    logic [WORD_W-1:0] st [BLOCK_WORDS];
    ks_word_t          w;
    int                a, b, c, d, j;
    seed[0] = 32'h61707865;
    seed[1] = 32'h3320646e;
    seed[2] = 32'h79622d32;
    seed[3] = 32'h6b206574;
    for (int k = 0; k < 4; k++) begin
      seed[4 + 2 * k] = cfg_shadow[k][31:0];
      seed[5 + 2 * k] = cfg_shadow[k][63:32];
    end
    seed[12] = ctr;
    seed[13] = cfg_shadow[int'(ccb_pkg::REG_NONCE_01)][31:0];
    seed[14] = cfg_shadow[int'(ccb_pkg::REG_NONCE_01)][63:32];
    seed[15] = cfg_shadow[int'(ccb_pkg::REG_NONCE_2)][31:0];
    for (int k = 0; k < BLOCK_WORDS; k++) st[k] = seed[k];
    for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
      for (int q = 0; q < 8; q++) begin
        // columns first, then diagonals
        j = q % 4;
        if (q < 4) begin
          a = j; b = 4 + j; c = 8 + j; d = 12 + j;
        end else begin
          a = j; b = 4 + (j + 1) % 4; c = 8 + (j + 2) % 4; d = 12 + (j + 3) % 4;
        end
        st[a] = st[a] + st[b]; st[d] = rol32(st[d] ^ st[a], 16);
        st[c] = st[c] + st[d]; st[b] = rol32(st[b] ^ st[c], 12);
        st[a] = st[a] + st[b]; st[d] = rol32(st[d] ^ st[a], 8);
        st[c] = st[c] + st[d]; st[b] = rol32(st[b] ^ st[c], 7);
      end
    end
    for (int k = 0; k < BLOCK_WORDS; k++) begin
      w.idx  = IDX_W'(k);
      w.word = st[k] + seed[k];
      w.last = (k == BLOCK_WORDS - 1);
      ks_pending = {ks_pending, w};
    end
  endfunction

  // counter channel driver, fed from ctr_queue
  always @(posedge clk_i) begin : drive_in
    logic              v;
    logic [WORD_W-1:0] c;
    v = in_valid_i;
    c = block_counter_i;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        push_keystream(block_counter_i);
        items_taken++;
        v = 1'b0;
        if (idle_on && $urandom_range(0, 3) == 0) in_gap = $urandom_range(1, 19);
      end
      if (!v) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (ctr_queue.size() > 0) begin
          c = ctr_queue.pop_front();
          v = 1'b1;
        end
      end
    end
    in_valid_i      <= v;
    block_counter_i <= c;
  end

  // keystream monitor and output stall bursts
  always @(posedge clk_i) begin : watch_out
    ks_word_t w;
    logic     s;
    s = 1'b0;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        words_seen++;
        if (ks_pending.size() == 0) begin
          $display("%0t: unexpected keystream word idx %0d data %08h last %0b", $time,
                   word_index_o, keystream_word_o, last_word_o);
          err_count++;
        end else begin
          w = ks_pending.pop_front();
          if (word_index_o !== w.idx) begin
            $display("%0t: word_index expected %0d actual %0d", $time, w.idx, word_index_o);
            err_count++;
          end
          if (keystream_word_o !== w.word) begin
            $display("%0t: keystream_word (idx %0d) expected %08h actual %08h", $time,
                     w.idx, w.word, keystream_word_o);
            err_count++;
          end
          if (last_word_o !== w.last) begin
            $display("%0t: last_word (idx %0d) expected %0b actual %0b", $time, w.idx,
                     w.last, last_word_o);
            err_count++;
          end
        end
      end
      if (out_hold > 0) begin
        out_hold--;
        s = 1'b1;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        out_hold = $urandom_range(1, 19);
      end
    end
    out_stall_i <= s;
  end

  // register write: setup cycle then access cycle
  task automatic cfg_write(input int idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(idx * 8);
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx < NUM_CFG_REGS)
      cfg_shadow[idx] = (idx == int'(ccb_pkg::REG_NONCE_2)) ? {32'h0, data[31:0]} : data;
    cfg_writes++;
  endtask

  task automatic cfg_all(input logic [CFG_DATA_W-1:0] k01, input logic [CFG_DATA_W-1:0] k23,
                         input logic [CFG_DATA_W-1:0] k45, input logic [CFG_DATA_W-1:0] k67,
                         input logic [CFG_DATA_W-1:0] n01, input logic [CFG_DATA_W-1:0] n2);
    cfg_write(int'(ccb_pkg::REG_KEY_01), k01);
    cfg_write(int'(ccb_pkg::REG_KEY_23), k23);
    cfg_write(int'(ccb_pkg::REG_KEY_45), k45);
    cfg_write(int'(ccb_pkg::REG_KEY_67), k67);
    cfg_write(int'(ccb_pkg::REG_NONCE_01), n01);
    cfg_write(int'(ccb_pkg::REG_NONCE_2), n2);
  endtask

  function automatic logic [CFG_DATA_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [WORD_W-1:0] rand_ctr();
    case ($urandom_range(0, 3))
      0, 1:    return $urandom;
      2:       return WORD_W'($urandom_range(0, 15));
      default: return 32'hffffffff - WORD_W'($urandom_range(0, 15));
    endcase
  endfunction

  // let queued items through and wait for every keystream word to come back
  task automatic drain();
    while (ctr_queue.size() > 0 || in_valid_i || ks_pending.size() > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // timeout
  initial begin
    #(5_000_000);
    $display("chacha20_block_function test failed");
    $finish;
  end

  initial begin
    for (int k = 0; k < NUM_CFG_REGS; k++) cfg_shadow[k] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // registers still at their reset value
    add_ctr(32'h0);
    add_ctr(32'hffffffff);
    drain();

    // key 00..1f, nonce 00 00 00 09 00 00 00 4a 00 00 00 00, counter 1
    cfg_all(64'h07060504_03020100, 64'h0f0e0d0c_0b0a0908, 64'h17161514_13121110,
            64'h1f1e1d1c_1b1a1918, 64'h4a000000_09000000, 64'h0);
    add_ctr(32'h1);
    add_ctr(32'h0);
    drain();

    // all ones, upper half of the nonce word 2 write has to be dropped
    cfg_all({64{1'b1}}, {64{1'b1}}, {64{1'b1}}, {64{1'b1}}, {64{1'b1}}, {64{1'b1}});
    add_ctr(32'h0);
    add_ctr(32'hffffffff);
    add_ctr(32'h80000000);
    add_ctr(32'h7fffffff);
    add_ctr(32'haaaaaaaa);
    add_ctr(32'h55555555);
    drain();

    // alternating pattern, then writes to unused slots that must change nothing
    cfg_all(64'h55555555_aaaaaaaa, 64'haaaaaaaa_55555555, 64'h55555555_aaaaaaaa,
            64'haaaaaaaa_55555555, 64'h55555555_aaaaaaaa, 64'hdeadbeef_aaaaaaaa);
    cfg_write(SPARE_IDX_LO, rand64());
    cfg_write(SPARE_IDX_HI, rand64());
    add_ctr(32'h00000001);
    add_ctr(32'h00010000);
    add_ctr(32'h40000000);
    add_ctr(32'hdeadbeef);
    drain();

    // random keys and nonces, random counters; the last phase runs without idling
    for (int p = 0; p < 5; p++) begin
      if (p == 4) idle_on = 1'b0;
      cfg_all(rand64(), rand64(), rand64(), rand64(), rand64(), rand64());
      for (int n = 0; n < 52; n++) add_ctr(rand_ctr());
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d counter items, %0d keystream words, %0d register writes",
             items_taken, words_seen, cfg_writes);
    $display("configs: reset, rfc vector, all ones, alternating, five random; %0d errors",
             err_count);
    if (err_count == 0 && ks_pending.size() == 0) begin
      $display("chacha20_block_function test passed");
    end else begin
      if (ks_pending.size() != 0)
        $display("%0t: %0d keystream words never arrived", $time, ks_pending.size());
      $display("chacha20_block_function test failed");
    end
    $finish;
  end

endmodule
